[hdl/cfq_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cfq_pkg: shared types and codes for the circular FIFO queue
// Operation codes, status codes and the packed payload structs of both
// channels.
// ----------------------------------------------------------------------------
package cfq_pkg;

  localparam int DATA_W = 32;
  localparam int CAP_W  = 7;

  // Operation codes
  localparam logic [1:0] OP_ENQ  = 2'd0;
  localparam logic [1:0] OP_DEQ  = 2'd1;
  localparam logic [1:0] OP_DISP = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  // Status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_OVF   = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic        [1:0]        op;
    logic signed [DATA_W-1:0] value;
  } cfq_in_t;

  typedef struct packed {
    logic        [1:0]        status;
    logic signed [DATA_W-1:0] data;
    logic                     last;
  } cfq_out_t;

endpackage
`default_nettype wire

[hdl/cfq_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cfq_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module cfq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[hdl/circular_fifo_queue_core.sv]
`default_nettype none
// Enqueue and dequeue: one transfer per cycle while not busy; results pass both stages.
// Display of n entries: n results on consecutive cycles, through both stages;
// busy is high while entries after the first are read, set by the single RAM read port.
// An empty display gives one empty status result.
// Reset (rst_n low, synchronous) empties the queue, zeroes both indices and
// sets capacity to DEPTH; slot RAM contents are not cleared.
// ----------------------------------------------------------------------------
// circular_fifo_queue_core: ring-buffer FIFO with runtime capacity
// Slot RAM, head/tail pointers, one shared wrap-increment unit and a small
// sequencer that walks the ring for display. Results pass a two-stage
// pipeline so that RAM read data and status line up.
// ----------------------------------------------------------------------------
module circular_fifo_queue_core
  import cfq_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire cfq_in_t          in_data,
  output logic                  out_valid,
  output cfq_out_t              out_data,
  input  wire logic             cfg_we,
  input  wire logic [CAP_W-1:0] cfg_wdata
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CAP_W-1:0] DEPTH_C = CAP_W'(DEPTH);
  localparam logic [CAP_W-1:0] ONE_C   = CAP_W'(1);

  // Sequencer states
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DISP = 1'b1;

  logic             state_r,  state_nxt;
  logic [IDX_W-1:0] head_r,   head_nxt;
  logic [IDX_W-1:0] tail_r,   tail_nxt;
  logic [IDX_W-1:0] walk_r,   walk_nxt;
  logic [CAP_W-1:0] count_r,  count_nxt;
  logic [CAP_W-1:0] remain_r, remain_nxt;
  logic [CAP_W-1:0] cap_r;

  // Stage 1: result control, waiting for RAM read data
  logic             s1_vld_r,    s1_vld_nxt;
  logic [1:0]       s1_status_r, s1_status_nxt;
  logic             s1_last_r,   s1_last_nxt;
  logic             s1_ram_r,    s1_ram_nxt;

  // Stage 2: output registers
  logic             out_valid_r;
  cfq_out_t         out_data_r;

  logic             accept;
  logic [IDX_W-1:0] wrap_in;
  logic [CAP_W-1:0] wrap_inc;
  logic [IDX_W-1:0] wrap_out;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [IDX_W-1:0] ram_raddr;
  logic [DATA_W-1:0] ram_rdata;
  logic [CAP_W-1:0] cap_clamp;

  assign busy   = (state_r == ST_DISP);
  assign accept = start && !busy;

  // Shared wrap-increment unit
  always_comb begin
    if (busy) begin
      wrap_in = walk_r;
    end else if (in_data.op == OP_ENQ) begin
      wrap_in = tail_r;
    end else begin
      wrap_in = head_r;
    end
    wrap_inc = CAP_W'(wrap_in) + ONE_C;
    wrap_out = (wrap_inc >= cap_r) ? '0 : wrap_inc[IDX_W-1:0];
  end

  assign ram_raddr = busy ? walk_r : head_r;

  // Sequencer and pointer update
  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    walk_nxt      = walk_r;
    count_nxt     = count_r;
    remain_nxt    = remain_r;
    s1_vld_nxt    = 1'b0;
    s1_status_nxt = STAT_OK;
    s1_last_nxt   = 1'b1;
    s1_ram_nxt    = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = '0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_data.op)
            OP_ENQ: begin
              s1_vld_nxt = 1'b1;
              if (count_r >= cap_r) begin
                s1_status_nxt = STAT_OVF;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = (count_r == '0) ? '0 : wrap_out;
                tail_nxt  = ram_waddr;
                if (count_r == '0) begin
                  head_nxt = '0;
                end
                count_nxt = count_r + ONE_C;
              end
            end
            OP_DEQ: begin
              s1_vld_nxt = 1'b1;
              if (count_r == '0) begin
                s1_status_nxt = STAT_EMPTY;
              end else begin
                s1_ram_nxt = 1'b1;
                if (count_r == ONE_C) begin
                  head_nxt = '0;
                  tail_nxt = '0;
                end else begin
                  head_nxt = wrap_out;
                end
                count_nxt = count_r - ONE_C;
              end
            end
            OP_DISP: begin
              s1_vld_nxt = 1'b1;
              if (count_r == '0) begin
                s1_status_nxt = STAT_EMPTY;
              end else begin
                s1_ram_nxt  = 1'b1;
                s1_last_nxt = (count_r == ONE_C);
                walk_nxt    = wrap_out;
                remain_nxt  = count_r - ONE_C;
                if (count_r != ONE_C) begin
                  state_nxt = ST_DISP;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_DISP: begin
        // one slot read per cycle along the ring
        s1_vld_nxt  = 1'b1;
        s1_ram_nxt  = 1'b1;
        s1_last_nxt = (remain_r == ONE_C);
        walk_nxt    = wrap_out;
        remain_nxt  = remain_r - ONE_C;
        if (remain_r == ONE_C) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Capacity write clamp
  always_comb begin
    if (cfg_wdata == '0) begin
      cap_clamp = ONE_C;
    end else if (cfg_wdata > DEPTH_C) begin
      cap_clamp = DEPTH_C;
    end else begin
      cap_clamp = cfg_wdata;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      cap_r       <= DEPTH_C;
      s1_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      s1_vld_r    <= s1_vld_nxt;
      out_valid_r <= s1_vld_r;
      if (cfg_we && count_r == '0) begin
        cap_r <= cap_clamp;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    walk_r             <= walk_nxt;
    remain_r           <= remain_nxt;
    s1_status_r        <= s1_status_nxt;
    s1_last_r          <= s1_last_nxt;
    s1_ram_r           <= s1_ram_nxt;
    out_data_r.status  <= s1_status_r;
    out_data_r.last    <= s1_last_r;
    out_data_r.data    <= s1_ram_r ? ram_rdata : '0;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Slot storage
  cfq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_data.value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Checks
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cap_r)
    else $error("occupancy above capacity");

  a_disp_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (count_r != '0 && remain_r != '0))
    else $error("display walk with nothing left");

  a_enq_count: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.op == OP_ENQ && count_r < cap_r) |=>
      count_r == $past(count_r) + ONE_C)
    else $error("enqueue did not grow occupancy");

  a_out_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == STAT_OK || out_data.status == STAT_OVF ||
                   out_data.status == STAT_EMPTY))
    else $error("bad result status");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != STAT_OK) |-> (out_data.data == '0 && out_data.last))
    else $error("error status with data or not last");

endmodule
`default_nettype wire

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for circular_fifo_queue_core
// Drives enqueue, dequeue, display and unused op codes through the command
// port, with bursty start timing and capacity changes between phases. A
// scoreboard class keeps its own copy of the ring and checks every result
// strobe field by field, in order.
// ----------------------------------------------------------------------------
module tb;
  import cfq_pkg::*;

  localparam int SLOTS = 64;

  // --------------------------------------------------------------------------
  // Scoreboard: predicts the results of each accepted transfer
  // --------------------------------------------------------------------------
  class ring_scoreboard;
    logic [DATA_W-1:0] slots [SLOTS];
    int unsigned       head_ptr;
    int unsigned       tail_ptr;
    int unsigned       capacity;
    bit                empty_flag;
    cfq_out_t          expected_results [$];
    int unsigned       error_count;

    function new();
      head_ptr    = 0;
      tail_ptr    = 0;
      capacity    = SLOTS;
      empty_flag  = 1'b1;
      error_count = 0;
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    function int unsigned next_slot(input int unsigned idx);
      return (idx + 1 >= capacity) ? 0 : idx + 1;
    endfunction

    function int unsigned fill_level();
      if (empty_flag) return 0;
      if (tail_ptr >= head_ptr) return tail_ptr - head_ptr + 1;
      return capacity - head_ptr + tail_ptr + 1;
    endfunction

    function void push_result(input logic [1:0] status, input logic [DATA_W-1:0] word,
                              input logic last);
      cfq_out_t r;
      r.status = status;
      r.data   = word;
      r.last   = last;
      expected_results.push_back(r);
    endfunction

    // Capacity only changes while the ring is empty; clamped to 1..SLOTS
    function void write_capacity(input logic [CAP_W-1:0] v);
      int unsigned c;
      c = 32'(v);
      if (!empty_flag) return;
      if (c < 1) c = 1;
      if (c > SLOTS) c = SLOTS;
      capacity = c;
    endfunction

    function void note_request(input cfq_in_t item);
      int unsigned n;
      int unsigned idx;
      logic [DATA_W-1:0] word;
      case (item.op)
        OP_ENQ: begin
          if (fill_level() >= capacity) begin
            push_result(STAT_OVF, '0, 1'b1);
          end else begin
            if (empty_flag) begin
              head_ptr   = 0;
              tail_ptr   = 0;
              empty_flag = 1'b0;
            end else begin
              tail_ptr = next_slot(tail_ptr);
            end
            slots[tail_ptr] = item.value;
            push_result(STAT_OK, '0, 1'b1);
          end
        end
        OP_DEQ: begin
          if (empty_flag) begin
            push_result(STAT_EMPTY, '0, 1'b1);
          end else begin
            word = slots[head_ptr];
            // taking the last entry returns both pointers to zero
            if (head_ptr == tail_ptr) begin
              head_ptr   = 0;
              tail_ptr   = 0;
              empty_flag = 1'b1;
            end else begin
              head_ptr = next_slot(head_ptr);
            end
            push_result(STAT_OK, word, 1'b1);
          end
        end
        OP_DISP: begin
          n   = fill_level();
          idx = head_ptr;
          if (n == 0) begin
            push_result(STAT_EMPTY, '0, 1'b1);
          end else begin
            for (int unsigned k = 0; k < n; k++) begin
              push_result(STAT_OK, slots[idx], (k + 1 == n));
              idx = next_slot(idx);
            end
          end
        end
        default: ;  // unused op code: no result, no state change
      endcase
    endfunction

    function void check_result(input cfq_out_t got);
      cfq_out_t want;
      if (expected_results.size() == 0) begin
        $error("unexpected result: status %0d data %0d last %0d",
               got.status, got.data, got.last);
        error_count++;
        return;
      end
      want = expected_results.pop_front();
      if (got.status !== want.status) begin
        $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
        error_count++;
      end
      if (got.data !== want.data) begin
        $error("data mismatch: expected %0d, actual %0d", want.data, got.data);
        error_count++;
      end
      if (got.last !== want.last) begin
        $error("last mismatch: expected %0d, actual %0d", want.last, got.last);
        error_count++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT signals and instance
  // --------------------------------------------------------------------------
  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             start     = 1'b0;
  logic             busy;
  cfq_in_t          in_data   = '0;
  logic             out_valid;
  cfq_out_t         out_data;
  logic             cfg_we    = 1'b0;
  logic [CAP_W-1:0] cfg_wdata = '0;

  ring_scoreboard sb = new();
  int unsigned    burst_left = 0;

  circular_fifo_queue_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #3_000_000;
    $display("simulation failed");
    $finish;
  end

  // Result monitor: every strobe is a transfer that cannot be held off
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (out_valid === 1'b1) begin
        sb.check_result(out_data);
      end else if (out_valid !== 1'b0) begin
        $error("out_valid is unknown");
        sb.error_count++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks
  // --------------------------------------------------------------------------

  // One command transfer; start is dropped between bursts
  task automatic send_item(input logic [1:0] op, input logic [DATA_W-1:0] value);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                : $urandom_range(1, 12);
    end
    burst_left--;
    start   <= 1'b1;
    in_data <= '{op, value};
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_request(in_data);
  endtask

  // Hold off until every expected result is back and the pipe has settled
  task automatic wait_idle();
    start <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CAP_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    sb.write_capacity(v);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CAP_W-1:0] pick_capacity();
    case ($urandom_range(0, 7))
      0: return 7'd1;
      1: return 7'd2;
      2: return 7'd0;
      3: return 7'd127;
      4: return 7'd64;
      5: return CAP_W'($urandom_range(0, 127));
      default: return CAP_W'($urandom_range(1, 64));
    endcase
  endfunction

  function automatic logic [1:0] pick_op(input int unsigned enq_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) return OP_NONE;
    if (r < 12) return OP_DISP;
    if (r < 12 + (enq_pct * 88) / 100) return OP_ENQ;
    return OP_DEQ;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : main
    int unsigned rand_items;
    int unsigned n_ops;
    int unsigned enq_pct;
    logic [1:0]  op;

    rand_items = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty queue, value extremes, unused op code
    send_item(OP_DISP, 32'h0);
    send_item(OP_DEQ, 32'h0);
    send_item(OP_NONE, 32'hFFFF_FFFF);
    send_item(OP_ENQ, 32'h7FFF_FFFF);
    send_item(OP_ENQ, 32'h8000_0000);
    send_item(OP_ENQ, 32'h0000_0000);
    send_item(OP_ENQ, 32'hFFFF_FFFF);
    send_item(OP_DISP, 32'h0);
    send_item(OP_NONE, 32'h0);
    // capacity write while holding entries must be ignored
    wait_idle();
    write_cfg(7'd5);
    repeat (5) send_item(OP_DEQ, 32'h0);

    // Capacity zero maps to one slot: overflow on the second enqueue
    wait_idle();
    write_cfg(7'd0);
    send_item(OP_ENQ, 32'h1234_5678);
    send_item(OP_ENQ, 32'h2222_2222);
    send_item(OP_DISP, 32'h0);
    send_item(OP_DEQ, 32'h0);

    // Three slots with wrap-around, then saturation above the depth
    wait_idle();
    write_cfg(7'd3);
    send_item(OP_ENQ, 32'hA);
    send_item(OP_ENQ, 32'hB);
    send_item(OP_ENQ, 32'hC);
    send_item(OP_DEQ, 32'h0);
    send_item(OP_ENQ, 32'hD);
    send_item(OP_ENQ, 32'hE);
    send_item(OP_DISP, 32'h0);
    while (!sb.empty_flag) send_item(OP_DEQ, 32'h0);
    wait_idle();
    write_cfg(7'd127);

    // Fill the whole ring, overflow it, and display every slot
    for (int i = 0; i < SLOTS + 1; i++) begin
      send_item(OP_ENQ, pick_value());
      rand_items++;
    end
    send_item(OP_DISP, 32'h0);
    rand_items++;

    // Random phases with a capacity change between them
    while (rand_items < 210) begin
      if ($urandom_range(0, 3) != 0) begin
        while (!sb.empty_flag) begin
          send_item(OP_DEQ, pick_value());
          rand_items++;
        end
      end
      wait_idle();
      write_cfg(pick_capacity());
      n_ops   = $urandom_range(15, 35);
      enq_pct = $urandom_range(20, 80);
      for (int i = 0; i < n_ops; i++) begin
        op = pick_op(enq_pct);
        send_item(op, pick_value());
        if (op != OP_NONE) rand_items++;
      end
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (sb.error_count == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
